// ----- rtl/core/ovpid_pkg.sv -----
// Shared types and constants of the oven PID controller with step mode.
// Stage payload structs, register map, mode codes and fixed-point constants.
// Has no dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package ovpid_pkg;

	// Field types of the sample and result beats, the gains and the percent value.
	typedef logic [15:0] thermo_t;
	typedef logic [12:0] temp_t;
	typedef logic [21:0] ms_t;
	typedef logic [15:0] duty_t;
	typedef logic [23:0] gain_t;
	typedef logic [22:0] pct_t;

	// Configuration port.
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_STEP_START = 3'd1,
		REG_TEMP_LIMIT = 3'd2,
		REG_GAIN_P     = 3'd3,
		REG_GAIN_I     = 3'd4,
		REG_GAIN_D     = 3'd5
	} reg_idx_t;

	// The unused fourth code runs the PID law, like MODE_PID.
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_STEP = 2'd1,
		MODE_PID  = 2'd2
	} mode_t;

	localparam logic [1:0] RST_MODE       = MODE_OFF;
	localparam ms_t        RST_STEP_START = 22'd10000;
	localparam temp_t      RST_TEMP_LIMIT = 13'd100;
	localparam gain_t      RST_GAIN_P     = 24'd49152;
	localparam gain_t      RST_GAIN_I     = 24'd164;
	localparam gain_t      RST_GAIN_D     = 24'd655360;

	// 100 percent in Q16.16 and full heater drive.
	localparam pct_t  PCT_FULL_Q16 = 23'd6553600;
	localparam duty_t DUTY_FULL    = 16'hFFFF;

	// floor(q / 100) is taken as (q * RECIP_100) >> RECIP_SHIFT, exact for q below 14e6.
	localparam int          RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP_100   = 24'((64'd1 << RECIP_SHIFT) / 100 + 1);

	typedef struct packed {
		logic [1:0] mode;
		ms_t        step_start_ms;
		temp_t      temp_limit;
		gain_t      gain_p;
		gain_t      gain_i_times_ts;
		gain_t      gain_d_over_ts;
	} cfg_t;

	typedef struct packed {
		thermo_t thermo_word;
		temp_t   reference;
		ms_t     elapsed_ms;
	} sample_t;

	// Status that rides along the pipeline next to the arithmetic.
	typedef struct packed {
		temp_t temperature;
		logic  probe_open;
		logic  limit_seen;
		logic  use_pid;
		logic  drive_full;
	} tag_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [13:0] err;
		logic signed [31:0] esum;
		logic signed [14:0] derr;
	} front_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [38:0] prod_p;
		logic signed [56:0] prod_i;
		logic signed [39:0] prod_d;
	} prod_t;

	typedef struct packed {
		tag_t tag;
		pct_t u;
	} ctl_t;

	typedef struct packed {
		duty_t duty;
		temp_t temperature;
		logic  probe_open;
		logic  limit_seen;
	} result_t;

endpackage

// ----- rtl/core/ovpid_ifs.sv -----
// Valid/ready channel interfaces for the sample and result beats.
// Depends on ovpid_pkg for the field types.
interface ovpid_sample_if;
	logic                 valid;
	logic                 ready;
	ovpid_pkg::thermo_t   thermo_word;
	ovpid_pkg::temp_t     reference;
	ovpid_pkg::ms_t       elapsed_ms;

	modport source (output valid, thermo_word, reference, elapsed_ms, input ready);
	modport sink   (input valid, thermo_word, reference, elapsed_ms, output ready);
endinterface

interface ovpid_result_if;
	logic                 valid;
	logic                 ready;
	ovpid_pkg::duty_t     duty;
	ovpid_pkg::temp_t     temperature;
	logic                 probe_open;
	logic                 limit_seen;

	modport source (output valid, duty, temperature, probe_open, limit_seen, input ready);
	modport sink   (input valid, duty, temperature, probe_open, limit_seen, output ready);
endinterface

// ----- rtl/core/ovpid_regs.sv -----
// APB-style configuration register file of the oven controller.
// Depends on ovpid_pkg for the register map and reset values.
module ovpid_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ovpid_pkg::APB_AW-1:0]   paddr,
	input  logic [ovpid_pkg::APB_DW-1:0]   pwdata,
	output logic [ovpid_pkg::APB_DW-1:0]   prdata,
	output logic                           pready,
	output ovpid_pkg::cfg_t                cfg
);
	ovpid_pkg::cfg_t      cfg_q;
	ovpid_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx    = ovpid_pkg::reg_idx_t'(paddr[ovpid_pkg::APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= ovpid_pkg::RST_MODE;
			cfg_q.step_start_ms   <= ovpid_pkg::RST_STEP_START;
			cfg_q.temp_limit      <= ovpid_pkg::RST_TEMP_LIMIT;
			cfg_q.gain_p          <= ovpid_pkg::RST_GAIN_P;
			cfg_q.gain_i_times_ts <= ovpid_pkg::RST_GAIN_I;
			cfg_q.gain_d_over_ts  <= ovpid_pkg::RST_GAIN_D;
		end else if (wr_en) begin
			unique case (idx)
				ovpid_pkg::REG_MODE:       cfg_q.mode            <= pwdata[1:0];
				ovpid_pkg::REG_STEP_START: cfg_q.step_start_ms   <= pwdata[21:0];
				ovpid_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit      <= pwdata[12:0];
				ovpid_pkg::REG_GAIN_P:     cfg_q.gain_p          <= pwdata[23:0];
				ovpid_pkg::REG_GAIN_I:     cfg_q.gain_i_times_ts <= pwdata[23:0];
				ovpid_pkg::REG_GAIN_D:     cfg_q.gain_d_over_ts  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ovpid_pkg::REG_MODE:       prdata = 32'(cfg_q.mode);
			ovpid_pkg::REG_STEP_START: prdata = 32'(cfg_q.step_start_ms);
			ovpid_pkg::REG_TEMP_LIMIT: prdata = 32'(cfg_q.temp_limit);
			ovpid_pkg::REG_GAIN_P:     prdata = 32'(cfg_q.gain_p);
			ovpid_pkg::REG_GAIN_I:     prdata = 32'(cfg_q.gain_i_times_ts);
			ovpid_pkg::REG_GAIN_D:     prdata = 32'(cfg_q.gain_d_over_ts);
			default:                   prdata = '0;
		endcase
	end
endmodule

// ----- rtl/core/ovpid_front.sv -----
// Input register, thermocouple decode, limit latch and PID state update.
// Depends on ovpid_pkg; feeds ovpid_mult.
module ovpid_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ovpid_pkg::cfg_t      cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ovpid_pkg::sample_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ovpid_pkg::front_t    out_data
);
	localparam logic [31:0] ESUM_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] ESUM_MIN = 32'h8000_0000;

	ovpid_pkg::sample_t  sample_s1;
	logic                valid_s1;
	ovpid_pkg::front_t   front_s2;
	logic                valid_s2;

	logic signed [31:0]  error_sum_q;
	logic signed [13:0]  last_error_q;
	logic                limit_q;

	logic                adv_s2;
	logic                take;
	ovpid_pkg::temp_t    temp;
	logic                limit_next;
	logic                use_pid;
	logic                drive_full;
	logic signed [13:0]  err;
	logic signed [32:0]  sum_wide;
	logic signed [31:0]  sum_next;
	logic signed [14:0]  derr;

	assign adv_s2    = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv_s2;
	assign take      = valid_s1 && adv_s2;
	assign out_valid = valid_s2;
	assign out_data  = front_s2;

	assign temp       = sample_s1.thermo_word[15:3];
	assign limit_next = limit_q || (temp > cfg.temp_limit);

	always_comb begin
		unique case (cfg.mode)
			ovpid_pkg::MODE_OFF: begin
				use_pid    = 1'b0;
				drive_full = 1'b0;
			end
			ovpid_pkg::MODE_STEP: begin
				use_pid    = 1'b0;
				drive_full = (sample_s1.elapsed_ms >= cfg.step_start_ms) && !limit_next;
			end
			default: begin
				use_pid    = 1'b1;
				drive_full = 1'b0;
			end
		endcase
	end

	// Control error and the saturating running sum.
	assign err      = $signed({1'b0, sample_s1.reference}) - $signed({1'b0, temp});
	assign sum_wide = $signed({error_sum_q[31], error_sum_q}) + 33'(err);
	assign derr     = 15'(err) - 15'(last_error_q);

	always_comb begin
		if (sum_wide[32] != sum_wide[31]) begin
			sum_next = sum_wide[32] ? ESUM_MIN : ESUM_MAX;
		end else begin
			sum_next = sum_wide[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			error_sum_q  <= '0;
			last_error_q <= '0;
			limit_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take) begin
				limit_q <= limit_next;
				if (use_pid) begin
					error_sum_q  <= sum_next;
					last_error_q <= err;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= in_data;
		end
		if (take) begin
			front_s2.tag.temperature <= temp;
			front_s2.tag.probe_open  <= sample_s1.thermo_word[2];
			front_s2.tag.limit_seen  <= limit_next;
			front_s2.tag.use_pid     <= use_pid;
			front_s2.tag.drive_full  <= drive_full;
			front_s2.err             <= err;
			front_s2.esum            <= sum_next;
			front_s2.derr            <= derr;
		end
	end
endmodule

// ----- rtl/core/ovpid_mult.sv -----
// Gain multiplications of the PID law, one registered stage.
// Depends on ovpid_pkg; fed by ovpid_front, feeds ovpid_sum.
module ovpid_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ovpid_pkg::cfg_t      cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ovpid_pkg::front_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ovpid_pkg::prod_t     out_data
);
	ovpid_pkg::prod_t    prod_s3;
	logic                valid_s3;

	logic signed [24:0]  gp;
	logic signed [24:0]  gi;
	logic signed [24:0]  gd;
	logic signed [38:0]  mul_p;
	logic signed [56:0]  mul_i;
	logic signed [39:0]  mul_d;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign out_data  = prod_s3;

	// Gains are unsigned; a zero sign bit keeps the products signed.
	assign gp    = $signed({1'b0, cfg.gain_p});
	assign gi    = $signed({1'b0, cfg.gain_i_times_ts});
	assign gd    = $signed({1'b0, cfg.gain_d_over_ts});
	assign mul_p = gp * $signed(in_data.err);
	assign mul_i = gi * $signed(in_data.esum);
	assign mul_d = gd * $signed(in_data.derr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s3.tag    <= in_data.tag;
			prod_s3.prod_p <= mul_p;
			prod_s3.prod_i <= mul_i;
			prod_s3.prod_d <= mul_d;
		end
	end
endmodule

// ----- rtl/core/ovpid_sum.sv -----
// Sum of the three PID terms and clamp to 0..100 percent in Q16.16.
// Depends on ovpid_pkg; fed by ovpid_mult, feeds ovpid_scale.
module ovpid_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ovpid_pkg::prod_t     in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ovpid_pkg::ctl_t      out_data
);
	localparam logic signed [58:0] FULL_S = 59'(ovpid_pkg::PCT_FULL_Q16);

	ovpid_pkg::ctl_t     ctl_s4;
	logic                valid_s4;
	logic signed [58:0]  total;
	ovpid_pkg::pct_t     u;

	assign in_ready  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;
	assign out_data  = ctl_s4;

	assign total = 59'($signed(in_data.prod_p)) + 59'($signed(in_data.prod_i))
		+ 59'($signed(in_data.prod_d));

	always_comb begin
		if (total[58]) begin
			u = '0;
		end else if (total > FULL_S) begin
			u = ovpid_pkg::PCT_FULL_Q16;
		end else begin
			u = total[22:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_s4.tag <= in_data.tag;
			ctl_s4.u   <= u;
		end
	end
endmodule

// ----- rtl/core/ovpid_scale.sv -----
// Percent-to-duty scaling, mode selection of the drive and the result register.
// Depends on ovpid_pkg; fed by ovpid_sum, drives the result channel.
module ovpid_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ovpid_pkg::ctl_t      in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ovpid_pkg::result_t   out_data
);
	ovpid_pkg::result_t  result_q;
	logic                valid_q;
	logic [7:0]          hi_ceil;
	ovpid_pkg::pct_t     q;
	logic [46:0]         prod;
	ovpid_pkg::duty_t    pid_duty;
	ovpid_pkg::duty_t    duty;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = result_q;

	// u*65535 >> 16 equals u minus ceil(u / 65536); the rest is a divide by 100.
	assign hi_ceil  = {1'b0, in_data.u[22:16]} + 8'(|in_data.u[15:0]);
	assign q        = in_data.u - 23'(hi_ceil);
	assign prod     = 47'(q) * 47'(ovpid_pkg::RECIP_100);
	assign pid_duty = prod[ovpid_pkg::RECIP_SHIFT +: 16];

	always_comb begin
		if (in_data.tag.use_pid) begin
			duty = pid_duty;
		end else if (in_data.tag.drive_full) begin
			duty = ovpid_pkg::DUTY_FULL;
		end else begin
			duty = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q.duty        <= duty;
			result_q.temperature <= in_data.tag.temperature;
			result_q.probe_open  <= in_data.tag.probe_open;
			result_q.limit_seen  <= in_data.tag.limit_seen;
		end
	end
endmodule

// ----- rtl/core/oven_pid_with_step_mode_unit.sv -----
// Top level of the oven heater controller: registers, pipeline and channel ports.
// Depends on ovpid_pkg, ovpid_ifs and the ovpid_* stage modules.
//
// Each sample beat carries a raw thermocouple word, the reference temperature and
// the elapsed time, and yields exactly one result beat with the heater duty, the
// decoded temperature (word bits 15..3, quarter degrees), the probe-open flag (bit 2)
// and the over-temperature latch. The mode register selects off (duty 0), step
// (full drive from step_start_ms on, forced to 0 once the latch is set) or PID; the
// unused mode code also runs PID. The block is a five-register pipeline: input
// register, decode and state update, gain multipliers, sum and clamp, and the result
// register that scales percent to duty. A sample is accepted every clock cycle while
// the result side is ready. The PID integrator and the latch sit in the decode stage,
// so their update loop (a 33-bit saturating add) is what lets consecutive samples
// follow each other without gaps. Stalls on the result side back up stage by stage;
// every stage holds one beat, so the input keeps accepting while empty slots remain.
// Configuration registers lie at byte addresses 4*i on the APB-style port, always
// ready; they should be written only while no sample is in flight. Send reference 0
// with the first, priming sample so the derivative term starts from a known error.
module oven_pid_with_step_mode_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	ovpid_sample_if.sink                   sample,
	ovpid_result_if.source                 result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ovpid_pkg::APB_AW-1:0]   paddr,
	input  logic [ovpid_pkg::APB_DW-1:0]   pwdata,
	output logic [ovpid_pkg::APB_DW-1:0]   prdata,
	output logic                           pready
);
	ovpid_pkg::cfg_t      cfg;
	ovpid_pkg::sample_t   sample_data;
	ovpid_pkg::front_t    front_data;
	ovpid_pkg::prod_t     prod_data;
	ovpid_pkg::ctl_t      ctl_data;
	ovpid_pkg::result_t   result_data;

	logic front_valid;
	logic front_ready;
	logic prod_valid;
	logic prod_ready;
	logic ctl_valid;
	logic ctl_ready;

	assign sample_data.thermo_word = sample.thermo_word;
	assign sample_data.reference   = sample.reference;
	assign sample_data.elapsed_ms  = sample.elapsed_ms;

	ovpid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Decode, limit latch and the integrator and last-error state.
	ovpid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_data   (sample_data),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	// Proportional, integral and derivative products.
	ovpid_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	// Sum and clamp to 0..100 percent.
	ovpid_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod_data),
		.out_valid (ctl_valid),
		.out_ready (ctl_ready),
		.out_data  (ctl_data)
	);

	// Duty scaling, mode selection and the result register.
	ovpid_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctl_valid),
		.in_ready  (ctl_ready),
		.in_data   (ctl_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result_data)
	);

	assign result.duty        = result_data.duty;
	assign result.temperature = result_data.temperature;
	assign result.probe_open  = result_data.probe_open;
	assign result.limit_seen  = result_data.limit_seen;
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for oven_pid_with_step_mode_unit: a scripted opening,
// then phased random samples.
// Depends on ovpid_pkg, the ovpid_sample_if / ovpid_result_if interfaces and the unit itself.
module tb;
	import ovpid_pkg::*;

	// The unused mode code, which must run the PID law.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// A register slot past the end of the map; writes there must be dropped.
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int SCRIPT_LEN = 28;

	typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

	// One row of the opening script: a register write or a sample beat. When
	// "typed" is set, the expected reading is the one written in the row.
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_sel;
		logic [31:0] value;
		sample_t     smp;
		logic        typed;
		result_t     want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	ovpid_sample_if sample_ch ();
	ovpid_result_if result_ch ();

	oven_pid_with_step_mode_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the register file, kept in step with every write.
	logic [1:0] cfg_mode       = RST_MODE;
	ms_t        cfg_step_start = RST_STEP_START;
	temp_t      cfg_limit      = RST_TEMP_LIMIT;
	gain_t      cfg_gain_p     = RST_GAIN_P;
	gain_t      cfg_gain_i     = RST_GAIN_I;
	gain_t      cfg_gain_d     = RST_GAIN_D;

	// Controller state as the unit should hold it.
	int integ    = 0;
	int prev_err = 0;
	bit over_temp = 1'b0;

	// Readings still owed by the unit, oldest first.
	result_t readings_due[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Receiver and sender stall on random cycles only while this is set.
	bit idling = 1'b1;
	int stall_left = 0;

	// Random sample generator state: the profile segment being tracked, the
	// run clock, and the highest temperature allowed while the latch must stay clear.
	int  seg_ref = 0;
	int  seg_span = 3;
	int  seg_left = 0;
	ms_t clock_ms = '0;
	int  temp_cap = 8191;

	// Opening script. Rows with an obvious answer carry it; the PID rows in the
	// middle of a tracking run are left to the model below.
	script_row_t script [SCRIPT_LEN] = '{
		// Off mode straight out of reset: zero drive, fields decoded, no latch.
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0000, 13'd0, 22'd0}, 1'b1, '{16'h0000, 13'd0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0004, 13'd8191, 22'd4194303}, 1'b1,
			'{16'h0000, 13'd0, 1'b1, 1'b0}},
		// Exactly at the default limit does not latch.
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0320, 13'd0, 22'd0}, 1'b1, '{16'h0000, 13'd100, 1'b0, 1'b0}},
		'{ROW_WRITE, REG_TEMP_LIMIT, 32'd8191, '0, 1'b0, '0},
		'{ROW_WRITE, REG_MODE, MODE_STEP, '0, 1'b0, '0},
		// Step edge at the default start time.
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0323, 13'd0, 22'd9999}, 1'b1, '{16'h0000, 13'd100, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'hFFFB, 13'd0, 22'd10000}, 1'b1,
			'{16'hFFFF, 13'd8191, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'hFFFF, 13'd8191, 22'd4194303}, 1'b1,
			'{16'hFFFF, 13'd8191, 1'b1, 1'b0}},
		'{ROW_WRITE, REG_STEP_START, 32'd0, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0008, 13'd0, 22'd0}, 1'b1, '{16'hFFFF, 13'd1, 1'b0, 1'b0}},
		// All ones must be trimmed to the 22-bit maximum start time.
		'{ROW_WRITE, REG_STEP_START, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h1234, 13'd0, 22'd4194302}, 1'b1,
			'{16'h0000, 13'd582, 1'b1, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0000, 13'd0, 22'd4194303}, 1'b1,
			'{16'hFFFF, 13'd0, 1'b0, 1'b0}},
		// PID with the reset gains: priming, then both rails of the clamp.
		'{ROW_WRITE, REG_MODE, MODE_PID, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0000, 13'd0, 22'd250}, 1'b1, '{16'h0000, 13'd0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0000, 13'd8191, 22'd500}, 1'b1,
			'{16'hFFFF, 13'd0, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'hFFF8, 13'd0, 22'd750}, 1'b1, '{16'h0000, 13'd8191, 1'b0, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0318, 13'd100, 22'd1000}, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0C63, 13'd400, 22'd1250}, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0C84, 13'd400, 22'd1500}, 1'b0, '0},
		// All ones into the mode register selects the spare code, still PID.
		'{ROW_WRITE, REG_MODE, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0C70, 13'd410, 22'd1750}, 1'b0, '0},
		'{ROW_WRITE, REG_UNMAPPED, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0CA0, 13'd395, 22'd2000}, 1'b0, '0},
		// With every gain at zero the drive is zero whatever the error.
		'{ROW_WRITE, REG_GAIN_P, 32'd0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_GAIN_I, 32'd0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_GAIN_D, 32'd0, '0, 1'b0, '0},
		'{ROW_SAMPLE, 3'd0, 32'd0, '{16'h0000, 13'd8191, 22'd2250}, 1'b1,
			'{16'h0000, 13'd0, 1'b0, 1'b0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Heater reading the unit should give for one sample. Updates the latch
	// in every mode; the integrator and last error move only under PID.
	function automatic result_t predict_heater(input sample_t s);
		result_t r;
		longint err, acc, u;
		r.temperature = s.thermo_word[15:3];
		r.probe_open = s.thermo_word[2];
		if (r.temperature > cfg_limit)
			over_temp = 1'b1;
		r.limit_seen = over_temp;
		r.duty = '0;
		if (cfg_mode == MODE_STEP) begin
			if (s.elapsed_ms >= cfg_step_start && !over_temp)
				r.duty = DUTY_FULL;
		end else if (cfg_mode != MODE_OFF) begin
			err = longint'(s.reference) - longint'(r.temperature);
			acc = longint'(integ) + err;
			if (acc > INTEG_MAX)
				acc = INTEG_MAX;
			else if (acc < INTEG_MIN)
				acc = INTEG_MIN;
			integ = int'(acc);
			u = longint'(cfg_gain_p) * err
				+ longint'(cfg_gain_i) * longint'(integ)
				+ longint'(cfg_gain_d) * (err - longint'(prev_err));
			prev_err = int'(err);
			if (u < 0)
				u = 0;
			else if (u > longint'(PCT_FULL_Q16))
				u = longint'(PCT_FULL_Q16);
			r.duty = duty_t'((u * longint'(DUTY_FULL)) / longint'(PCT_FULL_Q16));
		end
		return r;
	endfunction

	// Mostly a temperature tracking a held reference, as a profile would give;
	// about one sample in seven is pure noise. In step phases half the tracking samples
	// land within 32 milliseconds of the start time.
	function automatic sample_t make_sample(input bit stepping);
		sample_t s;
		int t;
		clock_ms = clock_ms + ms_t'($urandom_range(1, 400));
		if ($urandom_range(0, 99) < 15) begin
			s.thermo_word = 16'($urandom);
			s.reference = 13'($urandom);
			s.elapsed_ms = 22'($urandom);
		end else begin
			if (seg_left == 0) begin
				seg_ref = $urandom_range(0, 8191);
				case ($urandom_range(0, 2))
					0: seg_span = 3;
					1: seg_span = 20;
					default: seg_span = 200;
				endcase
				seg_left = $urandom_range(5, 40);
			end
			seg_left--;
			t = seg_ref + int'($urandom_range(0, 2 * seg_span)) - seg_span;
			if (t < 0)
				t = 0;
			if (t > 8191)
				t = 8191;
			s.reference = temp_t'(seg_ref);
			s.thermo_word = {temp_t'(t), 1'($urandom_range(0, 19) == 0), 2'($urandom)};
			if (stepping && $urandom_range(0, 1) == 1)
				s.elapsed_ms = cfg_step_start + ms_t'($urandom_range(0, 64)) - 22'd32;
			else
				s.elapsed_ms = clock_ms;
		end
		if (int'(s.thermo_word[15:3]) > temp_cap)
			s.thermo_word[15:3] = temp_t'(temp_cap);
		return s;
	endfunction

	// Presents one sample beat and books its reading once the beat is taken.
	// Valid is left high so a following beat can go out back to back.
	task automatic send_sample(input sample_t s, input bit typed, input result_t want);
		result_t pred;
		sample_ch.valid <= 1'b1;
		sample_ch.thermo_word <= s.thermo_word;
		sample_ch.reference <= s.reference;
		sample_ch.elapsed_ms <= s.elapsed_ms;
		do @(posedge clk); while (!sample_ch.ready);
		pred = predict_heater(s);
		readings_due.push_back(typed ? want : pred);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
	endtask

	// Register writes only go out with the pipeline empty; each ends by waiting on the clock
	// with psel low, so back-to-back writes never double-drive psel in one step.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MODE:       cfg_mode = value[1:0];
			REG_STEP_START: cfg_step_start = value[21:0];
			REG_TEMP_LIMIT: cfg_limit = value[12:0];
			REG_GAIN_P:     cfg_gain_p = value[23:0];
			REG_GAIN_I:     cfg_gain_i = value[23:0];
			REG_GAIN_D:     cfg_gain_d = value[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_phase(input int count, input bit stepping);
		for (int n = 0; n < count; n++) begin
			if (idling && $urandom_range(0, 3) == 0) begin
				sample_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			send_sample(make_sample(stepping), 1'b0, '0);
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Result side: ready drops in random bursts while idling.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Every result beat is matched against the oldest booked reading.
	always @(posedge clk) begin : reading_check
		result_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready) begin
			if (readings_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with none due, expected nothing, got duty %h",
					$time, result_ch.duty);
			end else begin
				want = readings_due.pop_front();
				check_field("duty", want.duty, result_ch.duty);
				check_field("temperature", 16'(want.temperature), 16'(result_ch.temperature));
				check_field("probe_open", 16'(want.probe_open), 16'(result_ch.probe_open));
				check_field("limit_seen", 16'(want.limit_seen), 16'(result_ch.limit_seen));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.thermo_word <= '0;
		sample_ch.reference <= '0;
		sample_ch.elapsed_ms <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE)
				reg_write(script[i].reg_sel, script[i].value);
			else
				send_sample(script[i].smp, script[i].typed, script[i].want);
		end

		// Step mode with the limit out of reach, so the latch stays clear and
		// the full-drive edge can be crossed many times.
		reg_write(REG_MODE, MODE_STEP);
		reg_write(REG_STEP_START, $urandom);
		run_phase(200, 1'b1);

		// Lower limit, but temperatures held at or below it; no stalls here.
		reg_write(REG_TEMP_LIMIT, $urandom_range(200, 8191));
		temp_cap = cfg_limit;
		reg_write(REG_STEP_START, $urandom_range(0, 1000));
		idling = 1'b0;
		run_phase(100, 1'b1);
		idling = 1'b1;

		// Closed loop with the default gains, then moderate random gains,
		// then every gain at its maximum so the clamp dominates.
		reg_write(REG_TEMP_LIMIT, 32'd8191);
		temp_cap = 8191;
		reg_write(REG_MODE, MODE_PID);
		reg_write(REG_GAIN_P, RST_GAIN_P);
		reg_write(REG_GAIN_I, RST_GAIN_I);
		reg_write(REG_GAIN_D, RST_GAIN_D);
		run_phase(200, 1'b0);
		reg_write(REG_GAIN_P, $urandom_range(0, 1 << 18));
		reg_write(REG_GAIN_I, $urandom_range(0, 1 << 10));
		reg_write(REG_GAIN_D, $urandom_range(0, 1 << 21));
		run_phase(150, 1'b0);
		reg_write(REG_GAIN_P, 32'h00FF_FFFF);
		reg_write(REG_GAIN_I, 32'h00FF_FFFF);
		reg_write(REG_GAIN_D, 32'h00FF_FFFF);
		run_phase(60, 1'b0);

		// Spare mode code with wide random gains. Halfway through, the sender
		// holds off until the pipeline has emptied completely.
		reg_write(REG_MODE, MODE_SPARE);
		reg_write(REG_GAIN_P, $urandom);
		reg_write(REG_GAIN_I, $urandom_range(0, 1 << 12));
		reg_write(REG_GAIN_D, $urandom);
		run_phase(70, 1'b0);
		wait_drained();
		run_phase(70, 1'b0);

		// Off mode with a low limit: the latch sets here and must never clear.
		reg_write(REG_MODE, MODE_OFF);
		reg_write(REG_TEMP_LIMIT, $urandom_range(0, 4000));
		run_phase(100, 1'b0);

		// Last stretch without stalls: step mode is now held at zero by the
		// latch, and PID runs on with a zero limit and the default gains.
		idling = 1'b0;
		reg_write(REG_MODE, MODE_STEP);
		reg_write(REG_STEP_START, $urandom_range(0, 4000));
		run_phase(100, 1'b1);
		reg_write(REG_TEMP_LIMIT, 32'd0);
		reg_write(REG_MODE, MODE_PID);
		reg_write(REG_GAIN_P, RST_GAIN_P);
		reg_write(REG_GAIN_I, RST_GAIN_I);
		reg_write(REG_GAIN_D, RST_GAIN_D);
		run_phase(150, 1'b0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/core/ovpid_pkg.sv
rtl/core/ovpid_ifs.sv
rtl/core/ovpid_regs.sv
rtl/core/ovpid_front.sv
rtl/core/ovpid_mult.sv
rtl/core/ovpid_sum.sv
rtl/core/ovpid_scale.sv
rtl/core/oven_pid_with_step_mode_unit.sv
sim/tb.sv
